// ===== rtl/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite frame sequencer package
// Shared widths, codes, item and configuration types for the sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

  // Largest sheet the sequencer addresses; the frame number stays 8 bits wide.
  localparam int MAX_FRAMES = 256;
  localparam int FRAME_CAP  = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;

  localparam int SIZE_W    = 9;
  localparam int PIX_W     = 13;
  localparam int PERIOD_W  = 24;
  localparam int FRAME_W   = 8;
  localparam int COORD_W   = 20;
  localparam int ACC_W     = 25;
  localparam int POS_W     = 9;
  localparam int LEN_W     = 9;
  localparam int FLAGS_W   = 3;
  localparam int ACTION_W  = 3;

  localparam int SIZE_MAX  = 256;
  localparam int PIX_MAX   = 4096;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = ACTION_W;
  localparam int OUT_TDATA_W = 56;

  // Output tdata layout
  localparam int OUT_FRAME_LSB    = 0;
  localparam int OUT_X_LSB        = OUT_FRAME_LSB + FRAME_W;
  localparam int OUT_Y_LSB        = OUT_X_LSB + COORD_W;
  localparam int OUT_PLAYING_BIT  = OUT_Y_LSB + COORD_W;
  localparam int OUT_FINISHED_BIT = OUT_PLAYING_BIT + 1;
  localparam int OUT_PAD_W        = OUT_TDATA_W - OUT_FINISHED_BIT - 1;

  // Radix-4 divider for column and row of a frame
  localparam int DIV_STEPS = FRAME_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int FLAG_LOOP   = 0;
  localparam int FLAG_RETURN = 1;
  localparam int FLAG_RANGE  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHEET_COLUMNS = 3'd0,
    CFG_SHEET_ROWS    = 3'd1,
    CFG_FRAME_WIDTH   = 3'd2,
    CFG_FRAME_HEIGHT  = 3'd3,
    CFG_FRAME_PERIOD  = 3'd4,
    CFG_RANGE_FIRST   = 3'd5,
    CFG_RANGE_LAST    = 3'd6,
    CFG_PLAY_FLAGS    = 3'd7
  } cfg_idx_e;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK   = 3'd0,
    ACT_START  = 3'd1,
    ACT_STOP   = 3'd2,
    ACT_PAUSE  = 3'd3,
    ACT_RESUME = 3'd4,
    ACT_IGNORE = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADVANCE,
    ST_FRAME,
    ST_DIV,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    action_e             action;
    logic [PERIOD_W-1:0] elapsed;
  } item_t;

  typedef struct packed {
    logic [SIZE_W-1:0]   sheet_columns;
    logic [SIZE_W-1:0]   sheet_rows;
    logic [PIX_W-1:0]    frame_width;
    logic [PIX_W-1:0]    frame_height;
    logic [PERIOD_W-1:0] frame_period;
    logic [FRAME_W-1:0]  range_first;
    logic [FRAME_W-1:0]  range_last;
    logic [FLAGS_W-1:0]  play_flags;
  } cfg_t;

endpackage

// ===== rtl/sfs_front.sv =====
// ----------------------------------------------------------------------------
// Sprite frame sequencer front end
// Accepts input items, decodes the action and hands them to the queue.
// ----------------------------------------------------------------------------
module sfs_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sfs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // elapsed[23:0]
  input  logic [sfs_pkg::IN_TUSER_W-1:0]   s_axis_tuser,  // action[2:0]
  input  logic                             full_i,
  output logic                             push_o,
  output sfs_pkg::item_t                   item_o
);

  logic           valid_q, valid_d;
  sfs_pkg::item_t item_q;
  sfs_pkg::item_t decoded;
  logic           accept;

  always_comb begin
    decoded.elapsed = '0;
    case (sfs_pkg::action_e'(s_axis_tuser))
      sfs_pkg::ACT_TICK: begin
        decoded.action  = sfs_pkg::ACT_TICK;
        decoded.elapsed = s_axis_tdata;
      end
      sfs_pkg::ACT_START:  decoded.action = sfs_pkg::ACT_START;
      sfs_pkg::ACT_STOP:   decoded.action = sfs_pkg::ACT_STOP;
      sfs_pkg::ACT_PAUSE:  decoded.action = sfs_pkg::ACT_PAUSE;
      sfs_pkg::ACT_RESUME: decoded.action = sfs_pkg::ACT_RESUME;
      default:             decoded.action = sfs_pkg::ACT_IGNORE;
    endcase
  end

  assign push_o        = valid_q && !full_i;
  assign s_axis_tready = !valid_q || !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign item_o        = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= decoded;
    end
  end

endmodule

// ===== rtl/sfs_queue.sv =====
// ----------------------------------------------------------------------------
// Sprite frame sequencer item queue
// Short FIFO that decouples the front end from the sequencing back end.
// ----------------------------------------------------------------------------
module sfs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sfs_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output sfs_pkg::item_t item_o
);

  sfs_pkg::item_t                    mem [sfs_pkg::QUEUE_DEPTH];
  logic [sfs_pkg::QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [sfs_pkg::QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [sfs_pkg::QCNT_W-1:0]        cnt_q, cnt_d;

  assign full_o  = (cnt_q == sfs_pkg::QCNT_W'(sfs_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == sfs_pkg::QPTR_W'(sfs_pkg::QUEUE_DEPTH - 1)) ? '0
               : wr_ptr_q + sfs_pkg::QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == sfs_pkg::QPTR_W'(sfs_pkg::QUEUE_DEPTH - 1)) ? '0
               : rd_ptr_q + sfs_pkg::QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + sfs_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - sfs_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/sfs_back.sv =====
// ----------------------------------------------------------------------------
// Sprite frame sequencer back end
// Runs the play state, derives the shown frame and its pixel position.
// ----------------------------------------------------------------------------
module sfs_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sfs_pkg::cfg_t                   cfg_i,
  input  logic                            head_valid_i,
  input  sfs_pkg::item_t                  head_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // frame_number[7:0], frame_x[27:8], frame_y[47:28], playing[48],
  // finished[49], zero pad[55:50]
  output logic [sfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int FW = sfs_pkg::FRAME_W;

  // Derived configuration, two register stages
  logic [sfs_pkg::SIZE_W-1:0]   cols_c, rows_c;
  logic [sfs_pkg::PIX_W-1:0]    fw_c, fh_c;
  logic [2*sfs_pkg::SIZE_W-1:0] n_raw_q;
  logic [sfs_pkg::SIZE_W-1:0]   cols_q;
  logic [sfs_pkg::PIX_W-1:0]    fw_q, fh_q;

  logic [sfs_pkg::SIZE_W-1:0]   n_sat;
  logic [FW-1:0]                seq_first, seq_span;
  logic                         seq_down, seq_empty;
  logic [sfs_pkg::LEN_W-1:0]    seq_len;
  logic [FW-1:0]                first_q, span_q;
  logic                         down_q, empty_q;
  logic [sfs_pkg::LEN_W-1:0]    len_q;

  logic ret, loop_cfg;

  always_comb begin
    cols_c = (cfg_i.sheet_columns == '0) ? sfs_pkg::SIZE_W'(1)
           : (cfg_i.sheet_columns > sfs_pkg::SIZE_W'(sfs_pkg::SIZE_MAX))
             ? sfs_pkg::SIZE_W'(sfs_pkg::SIZE_MAX) : cfg_i.sheet_columns;
    rows_c = (cfg_i.sheet_rows == '0) ? sfs_pkg::SIZE_W'(1)
           : (cfg_i.sheet_rows > sfs_pkg::SIZE_W'(sfs_pkg::SIZE_MAX))
             ? sfs_pkg::SIZE_W'(sfs_pkg::SIZE_MAX) : cfg_i.sheet_rows;
    fw_c   = (cfg_i.frame_width == '0) ? sfs_pkg::PIX_W'(1)
           : (cfg_i.frame_width > sfs_pkg::PIX_W'(sfs_pkg::PIX_MAX))
             ? sfs_pkg::PIX_W'(sfs_pkg::PIX_MAX) : cfg_i.frame_width;
    fh_c   = (cfg_i.frame_height == '0) ? sfs_pkg::PIX_W'(1)
           : (cfg_i.frame_height > sfs_pkg::PIX_W'(sfs_pkg::PIX_MAX))
             ? sfs_pkg::PIX_W'(sfs_pkg::PIX_MAX) : cfg_i.frame_height;
  end

  assign ret      = cfg_i.play_flags[sfs_pkg::FLAG_RETURN];
  assign loop_cfg = cfg_i.play_flags[sfs_pkg::FLAG_LOOP];

  always_comb begin
    n_sat = (n_raw_q > (2*sfs_pkg::SIZE_W)'(sfs_pkg::FRAME_CAP))
          ? sfs_pkg::SIZE_W'(sfs_pkg::FRAME_CAP) : n_raw_q[sfs_pkg::SIZE_W-1:0];
    if (cfg_i.play_flags[sfs_pkg::FLAG_RANGE]) begin
      seq_first = cfg_i.range_first;
      seq_down  = cfg_i.range_first > cfg_i.range_last;
      seq_empty = cfg_i.range_first == cfg_i.range_last;
      seq_span  = seq_down ? cfg_i.range_first - cfg_i.range_last
                           : cfg_i.range_last - cfg_i.range_first;
      if (!ret) begin
        seq_len = {1'b0, seq_span} + sfs_pkg::LEN_W'(1);
      end else if (loop_cfg) begin
        seq_len = {seq_span, 1'b0};
      end else begin
        seq_len = {seq_span, 1'b1};
      end
    end else begin
      seq_first = '0;
      seq_down  = 1'b0;
      seq_empty = 1'b0;
      seq_span  = FW'(n_sat - sfs_pkg::SIZE_W'(1));
      if (!ret) begin
        seq_len = n_sat;
      end else if (seq_span == '0) begin
        seq_len = sfs_pkg::LEN_W'(1);
      end else begin
        seq_len = {seq_span, 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_raw_q <= cols_c * rows_c;
    cols_q  <= cols_c;
    fw_q    <= fw_c;
    fh_q    <= fh_c;
    first_q <= seq_first;
    span_q  <= seq_span;
    down_q  <= seq_down;
    empty_q <= seq_empty;
    len_q   <= seq_len;
  end

  // Play state and sequencer
  sfs_pkg::back_state_e        state_q, state_d;
  logic                        playing_q, playing_d;
  logic [sfs_pkg::POS_W-1:0]   pos_q, pos_d;
  logic [sfs_pkg::ACC_W-1:0]   acc_q, acc_d;
  logic                        finished_q, finished_d;

  logic [FW-1:0]               frame_q, frame_d;
  logic [FW-1:0]               num_q, num_d;
  logic [FW-1:0]               rem_q, rem_d;
  logic [FW-1:0]               quot_q, quot_d;
  logic [sfs_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;

  logic                        out_valid_q, out_valid_d;
  logic [sfs_pkg::OUT_TDATA_W-1:0] out_data_q;
  logic                        out_free, out_load;

  logic [sfs_pkg::ACC_W:0]     acc_sum;
  logic [sfs_pkg::POS_W:0]     pos_inc;
  logic [sfs_pkg::POS_W-1:0]   p_clamp, off;
  logic [FW-1:0]               last_f, frame_calc;
  logic [FW+2:0]               div_r, div_c1, div_c2, div_c3, div_rr;
  logic [1:0]                  digit;
  logic [FW+sfs_pkg::PIX_W-1:0] prod_x, prod_y;

  assign out_free = !out_valid_q || m_axis_tready;
  assign acc_sum  = {1'b0, acc_q} + (sfs_pkg::ACC_W+1)'(head_i.elapsed);
  assign pos_inc  = {1'b0, pos_q} + (sfs_pkg::POS_W+1)'(1);

  // Shown frame at the clamped position
  always_comb begin
    p_clamp = (pos_q < len_q) ? pos_q : len_q - sfs_pkg::LEN_W'(1);
    off     = p_clamp - {1'b0, span_q};
    last_f  = down_q ? first_q - span_q : first_q + span_q;
    if (empty_q) begin
      frame_calc = first_q;
    end else if (p_clamp <= {1'b0, span_q}) begin
      frame_calc = down_q ? first_q - p_clamp[FW-1:0] : first_q + p_clamp[FW-1:0];
    end else begin
      frame_calc = down_q ? last_f + off[FW-1:0] : last_f - off[FW-1:0];
    end
  end

  // One radix-4 digit of frame / columns
  always_comb begin
    div_r  = {1'b0, rem_q, num_q[FW-1:FW-2]};
    div_c1 = {2'b00, cols_q};
    div_c2 = {1'b0, cols_q, 1'b0};
    div_c3 = div_c1 + div_c2;
    if (div_r >= div_c3) begin
      digit  = 2'd3;
      div_rr = div_r - div_c3;
    end else if (div_r >= div_c2) begin
      digit  = 2'd2;
      div_rr = div_r - div_c2;
    end else if (div_r >= div_c1) begin
      digit  = 2'd1;
      div_rr = div_r - div_c1;
    end else begin
      digit  = 2'd0;
      div_rr = div_r;
    end
  end

  assign prod_x = rem_q * fw_q;
  assign prod_y = quot_q * fh_q;

  always_comb begin
    state_d    = state_q;
    playing_d  = playing_q;
    pos_d      = pos_q;
    acc_d      = acc_q;
    finished_d = finished_q;
    frame_d    = frame_q;
    num_d      = num_q;
    rem_d      = rem_q;
    quot_d     = quot_q;
    cnt_d      = cnt_q;
    pop_o      = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      sfs_pkg::ST_IDLE: begin
        if (head_valid_i) begin
          pop_o      = 1'b1;
          finished_d = 1'b0;
          state_d    = sfs_pkg::ST_FRAME;
          case (head_i.action)
            sfs_pkg::ACT_TICK: begin
              if (playing_q) begin
                if (empty_q) begin
                  playing_d = 1'b0;
                end else begin
                  acc_d   = acc_sum[sfs_pkg::ACC_W] ? '1 : acc_sum[sfs_pkg::ACC_W-1:0];
                  state_d = sfs_pkg::ST_ADVANCE;
                end
              end
            end
            sfs_pkg::ACT_START: begin
              pos_d     = '0;
              playing_d = !empty_q;
            end
            sfs_pkg::ACT_STOP: begin
              pos_d     = '0;
              playing_d = 1'b0;
            end
            sfs_pkg::ACT_PAUSE:  playing_d = 1'b0;
            sfs_pkg::ACT_RESUME: playing_d = !empty_q;
            default: ;
          endcase
        end
      end
      sfs_pkg::ST_ADVANCE: begin
        if (acc_q >= sfs_pkg::ACC_W'(cfg_i.frame_period)) begin
          acc_d = acc_q - sfs_pkg::ACC_W'(cfg_i.frame_period);
          if (pos_inc >= {1'b0, len_q}) begin
            if (loop_cfg) begin
              pos_d = '0;
            end else begin
              pos_d      = len_q - sfs_pkg::LEN_W'(1);
              playing_d  = 1'b0;
              finished_d = 1'b1;
            end
          end else begin
            pos_d = pos_inc[sfs_pkg::POS_W-1:0];
          end
        end
        state_d = sfs_pkg::ST_FRAME;
      end
      sfs_pkg::ST_FRAME: begin
        frame_d = frame_calc;
        num_d   = frame_calc;
        rem_d   = '0;
        quot_d  = '0;
        cnt_d   = '0;
        state_d = sfs_pkg::ST_DIV;
      end
      sfs_pkg::ST_DIV: begin
        num_d  = {num_q[FW-3:0], 2'b00};
        rem_d  = div_rr[FW-1:0];
        quot_d = {quot_q[FW-3:0], digit};
        cnt_d  = cnt_q + sfs_pkg::DIV_CNT_W'(1);
        if (cnt_q == sfs_pkg::DIV_CNT_W'(sfs_pkg::DIV_STEPS - 1)) begin
          state_d = sfs_pkg::ST_EMIT;
        end
      end
      sfs_pkg::ST_EMIT: begin
        // hold the finished item until the output register frees up
        if (out_free) begin
          out_load = 1'b1;
          state_d  = sfs_pkg::ST_IDLE;
        end
      end
      default: state_d = sfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfs_pkg::ST_IDLE;
      playing_q   <= 1'b0;
      pos_q       <= '0;
      acc_q       <= '0;
      finished_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      playing_q   <= playing_d;
      pos_q       <= pos_d;
      acc_q       <= acc_d;
      finished_q  <= finished_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    num_q   <= num_d;
    rem_q   <= rem_d;
    quot_q  <= quot_d;
    cnt_q   <= cnt_d;
    if (out_load) begin
      out_data_q <= {{sfs_pkg::OUT_PAD_W{1'b0}}, finished_q, playing_q,
                     prod_y[sfs_pkg::COORD_W-1:0], prod_x[sfs_pkg::COORD_W-1:0],
                     frame_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/sprite_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// Sprite frame sequencer
// Steps a sprite-sheet animation on tick items and reports the shown frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_axis: tuser carries the action (tick, start, stop, pause,
//   resume), tdata the elapsed time in unsigned Q8.16 seconds for ticks.
//   Output channel m_axis: exactly one item per input item, with frame
//   number, pixel x and y of the frame in the sheet, playing and finished.
//   Configuration: write cfg_data_i to register cfg_index_i while cfg_we_i is
//   high; write only while no item is in flight.
//   Flow: an accepted item passes the front register and the queue; the back
//   end then takes it from IDLE through FRAME, its 4-step radix-4 column/row
//   divider and EMIT, with ADVANCE before FRAME for a tick while playing, one item at a time.
//   The front register and a 2-entry queue keep taking items while the back
//   end works. When the receiver stalls, the finished item is held in the
//   output register, the back end waits with the next one, and input
//   tready drops once the queue and front register are full.
//   Reset clears play state, position and time accumulator and loads the
//   register defaults (1x1 sheet, 1x1 frame, zero period, whole sheet).
// ----------------------------------------------------------------------------
module sprite_frame_sequencer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sfs_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // elapsed[23:0]
  input  logic [sfs_pkg::IN_TUSER_W-1:0]   s_axis_tuser,  // action[2:0]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // frame_number[7:0], frame_x[27:8], frame_y[47:28], playing[48],
  // finished[49], zero pad[55:50]
  output logic [sfs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  sfs_pkg::cfg_t  cfg_q, cfg_d;
  logic           push, full, pop, head_valid;
  sfs_pkg::item_t front_item, head_item;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (sfs_pkg::cfg_idx_e'(cfg_index_i))
        sfs_pkg::CFG_SHEET_COLUMNS: cfg_d.sheet_columns = cfg_data_i[sfs_pkg::SIZE_W-1:0];
        sfs_pkg::CFG_SHEET_ROWS:    cfg_d.sheet_rows    = cfg_data_i[sfs_pkg::SIZE_W-1:0];
        sfs_pkg::CFG_FRAME_WIDTH:   cfg_d.frame_width   = cfg_data_i[sfs_pkg::PIX_W-1:0];
        sfs_pkg::CFG_FRAME_HEIGHT:  cfg_d.frame_height  = cfg_data_i[sfs_pkg::PIX_W-1:0];
        sfs_pkg::CFG_FRAME_PERIOD:  cfg_d.frame_period  = cfg_data_i[sfs_pkg::PERIOD_W-1:0];
        sfs_pkg::CFG_RANGE_FIRST:   cfg_d.range_first   = cfg_data_i[sfs_pkg::FRAME_W-1:0];
        sfs_pkg::CFG_RANGE_LAST:    cfg_d.range_last    = cfg_data_i[sfs_pkg::FRAME_W-1:0];
        sfs_pkg::CFG_PLAY_FLAGS:    cfg_d.play_flags    = cfg_data_i[sfs_pkg::FLAGS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sheet_columns <= sfs_pkg::SIZE_W'(1);
      cfg_q.sheet_rows    <= sfs_pkg::SIZE_W'(1);
      cfg_q.frame_width   <= sfs_pkg::PIX_W'(1);
      cfg_q.frame_height  <= sfs_pkg::PIX_W'(1);
      cfg_q.frame_period  <= '0;
      cfg_q.range_first   <= '0;
      cfg_q.range_last    <= '0;
      cfg_q.play_flags    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sfs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .push_o        (push),
    .item_o        (front_item)
  );

  sfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  sfs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_valid_i  (head_valid),
    .head_i        (head_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("queue pushed while full");

  a_finished_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[sfs_pkg::OUT_FINISHED_BIT])
      |-> !m_axis_tdata[sfs_pkg::OUT_PLAYING_BIT])
    else $error("finished item still reports playing");
`endif

endmodule

// ===== dv/sprite_frame_sequencer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sprite frame sequencer testbench
// Drives tick, start, stop, pause, resume and unused action items into the
// sequencer under changing sheet, range, period and play settings, predicts
// each shown frame, its pixel position and the playing and finished flags,
// and checks every output item in order. Both stream sides idle at random,
// with a long receiver hold-off on every tenth settings run that backs up the input.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_tb;
  import sfs_pkg::*;

  localparam int unsigned ACC_LIMIT     = (1 << ACC_W) - 1;
  localparam int unsigned ELAPSED_MAX   = (1 << PERIOD_W) - 1;
  localparam int          ITEM_TARGET   = 480;
  localparam int          SETTLE_CYCLES = 14;
  localparam int          HOLD_CYCLES   = 220;
  localparam int          QUIET_LIMIT   = 3000;

  localparam logic [PERIOD_W-1:0] ELAPSED_TOP = '1;

  // action codes the block does not know
  localparam logic [ACTION_W-1:0] ACT_UNUSED_A = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_B = 3'd6;

  typedef struct {
    logic [FRAME_W-1:0] frame;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               playing;
    logic               finished;
  } shown_frame_t;

  class frame_scoreboard;
    cfg_t         cfg;
    bit           playing;
    int unsigned  pos;
    int unsigned  acc;
    shown_frame_t shown_q[$];
    int           errors;
    int           taken;
    int           checked;
    int           ticks;
    int           finishes;
    int           wraps;
    int           empty_range;

    function new();
      cfg = '0;
      cfg.sheet_columns = SIZE_W'(1);
      cfg.sheet_rows    = SIZE_W'(1);
      cfg.frame_width   = PIX_W'(1);
      cfg.frame_height  = PIX_W'(1);
    endfunction

    function int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void write_cfg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_SHEET_COLUMNS: cfg.sheet_columns = v[SIZE_W-1:0];
        CFG_SHEET_ROWS:    cfg.sheet_rows    = v[SIZE_W-1:0];
        CFG_FRAME_WIDTH:   cfg.frame_width   = v[PIX_W-1:0];
        CFG_FRAME_HEIGHT:  cfg.frame_height  = v[PIX_W-1:0];
        CFG_FRAME_PERIOD:  cfg.frame_period  = v[PERIOD_W-1:0];
        CFG_RANGE_FIRST:   cfg.range_first   = v[FRAME_W-1:0];
        CFG_RANGE_LAST:    cfg.range_last    = v[FRAME_W-1:0];
        CFG_PLAY_FLAGS:    cfg.play_flags    = v[FLAGS_W-1:0];
        default: ;
      endcase
    endfunction

    // length of the play sequence, zero for an empty range
    function int unsigned seq_len(output int unsigned first, output int unsigned span,
                                  output bit down);
      int unsigned n, lo, hi;
      bit          ret, loop;
      ret  = cfg.play_flags[FLAG_RETURN];
      loop = cfg.play_flags[FLAG_LOOP];
      if (cfg.play_flags[FLAG_RANGE]) begin
        lo    = 32'(cfg.range_first);
        hi    = 32'(cfg.range_last);
        first = lo;
        down  = lo > hi;
        if (lo == hi) begin
          span = 0;
          down = 1'b0;
          return 0;
        end
        span = down ? lo - hi : hi - lo;
        if (!ret) return span + 1;
        return loop ? 2 * span : 2 * span + 1;
      end
      n = clamp_u(32'(cfg.sheet_columns), 1, SIZE_MAX)
        * clamp_u(32'(cfg.sheet_rows), 1, SIZE_MAX);
      if (n > FRAME_CAP) n = FRAME_CAP;
      first = 0;
      down  = 1'b0;
      span  = n - 1;
      if (!ret) return span + 1;
      return span == 0 ? 1 : 2 * span;
    endfunction

    // walk out to the far end, then come back past it
    function int unsigned frame_at(int unsigned p, int unsigned first, int unsigned span,
                                   bit down);
      int unsigned far_end, back;
      if (p <= span) return down ? first - p : first + p;
      back    = p - span;
      far_end = down ? first - span : first + span;
      return down ? far_end + back : far_end - back;
    endfunction

    function void note_item(logic [ACTION_W-1:0] act, logic [PERIOD_W-1:0] elapsed);
      int unsigned  len, first, span, p, frame, cols, fw, fh;
      bit           down, fin;
      shown_frame_t s;
      fin = 1'b0;
      len = seq_len(first, span, down);
      taken++;
      case (act)
        ACT_TICK: begin
          ticks++;
          if (playing) begin
            if (len == 0) begin
              playing = 1'b0;
            end else begin
              acc = acc + 32'(elapsed);
              if (acc > ACC_LIMIT) acc = ACC_LIMIT;
              if (acc >= 32'(cfg.frame_period)) begin
                acc = acc - 32'(cfg.frame_period);
                if (pos + 1 >= len) begin
                  if (cfg.play_flags[FLAG_LOOP]) begin
                    pos = 0;
                    wraps++;
                  end else begin
                    pos     = len - 1;
                    playing = 1'b0;
                    fin     = 1'b1;
                    finishes++;
                  end
                end else begin
                  pos++;
                end
              end
            end
          end
        end
        ACT_START: begin
          pos     = 0;
          playing = len != 0;
        end
        ACT_STOP: begin
          playing = 1'b0;
          pos     = 0;
        end
        ACT_PAUSE:  playing = 1'b0;
        ACT_RESUME: playing = len != 0;
        default: ;
      endcase

      if (len == 0) begin
        frame = 32'(cfg.range_first);
        empty_range++;
      end else begin
        p     = pos < len ? pos : len - 1;
        frame = frame_at(p, first, span, down);
      end
      frame = frame & 32'hFF;
      cols  = clamp_u(32'(cfg.sheet_columns), 1, SIZE_MAX);
      fw    = clamp_u(32'(cfg.frame_width), 1, PIX_MAX);
      fh    = clamp_u(32'(cfg.frame_height), 1, PIX_MAX);

      s.frame    = frame[FRAME_W-1:0];
      s.x        = COORD_W'((frame % cols) * fw);
      s.y        = COORD_W'((frame / cols) * fh);
      s.playing  = playing;
      s.finished = fin;
      shown_q.insert(shown_q.size(), s);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d);
      shown_frame_t want;
      if (shown_q.size() == 0) begin
        $error("output item with no item waiting, tdata %h", d);
        errors++;
        return;
      end
      want = shown_q.pop_front();
      checked++;
      compare_field("frame_number", 32'(want.frame), 32'(d[OUT_FRAME_LSB +: FRAME_W]));
      compare_field("frame_x", 32'(want.x), 32'(d[OUT_X_LSB +: COORD_W]));
      compare_field("frame_y", 32'(want.y), 32'(d[OUT_Y_LSB +: COORD_W]));
      compare_field("playing", 32'(want.playing), 32'(d[OUT_PLAYING_BIT]));
      compare_field("finished", 32'(want.finished), 32'(d[OUT_FINISHED_BIT]));
    endfunction

    function int pending();
      return shown_q.size();
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata;   // elapsed[23:0]
  logic [IN_TUSER_W-1:0]   s_axis_tuser;   // action[2:0]
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  // frame_number[7:0], frame_x[27:8], frame_y[47:28], playing[48],
  // finished[49], zero pad[55:50]
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;

  frame_scoreboard sb;
  bit              offering;
  int              burst_left;
  bit              hold_req;
  int              hold_cnt;
  int              stall_mode;
  int              stall_cycle;
  int              quiet_cycles;
  int              settings_run;

  sprite_frame_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // check output items, then pick next tready from the stall pattern
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (stall_cycle == 0) begin
      stall_mode  = $urandom_range(0, 3);
      stall_cycle = $urandom_range(20, 80);
    end else begin
      stall_cycle--;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (stall_cycle % 5 != 2);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no handshake for %0d cycles, %0d items outstanding",
                 QUIET_LIMIT, sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic push_item(input logic [ACTION_W-1:0] act, input logic [PERIOD_W-1:0] el);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= el;
    s_axis_tuser  <= act;
    offering = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(act, el);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // hold the input until every output item is back, then let the block go quiet
  task automatic settle();
    if (offering) begin
      s_axis_tvalid <= 1'b0;
      offering = 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    sb.write_cfg(idx, v);
  endtask

  task automatic program_regs(input cfg_t c);
    put_reg(CFG_SHEET_COLUMNS, CFG_DATA_W'(c.sheet_columns));
    put_reg(CFG_SHEET_ROWS, CFG_DATA_W'(c.sheet_rows));
    put_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(c.frame_width));
    put_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(c.frame_height));
    put_reg(CFG_FRAME_PERIOD, CFG_DATA_W'(c.frame_period));
    put_reg(CFG_RANGE_FIRST, CFG_DATA_W'(c.range_first));
    put_reg(CFG_RANGE_LAST, CFG_DATA_W'(c.range_last));
    put_reg(CFG_PLAY_FLAGS, CFG_DATA_W'(c.play_flags));
    cfg_we_i <= 1'b0;
    settings_run++;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size(int unsigned typical_max);
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return 9'd511;
      2:       return 9'd256;
      3:       return SIZE_W'($urandom_range(0, 511));
      default: return SIZE_W'($urandom_range(1, typical_max));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixels();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 13'd4096;
      2:       return 13'd8191;
      default: return PIX_W'($urandom_range(0, 8191));
    endcase
  endfunction

  function automatic cfg_t rand_settings();
    cfg_t        c;
    int unsigned first, delta;
    c.sheet_columns = pick_size(4);
    c.sheet_rows    = pick_size(3);
    c.frame_width   = pick_pixels();
    c.frame_height  = pick_pixels();
    case ($urandom_range(0, 9))
      0, 1:    c.frame_period = '0;
      2:       c.frame_period = ELAPSED_TOP;
      3:       c.frame_period = 24'd1;
      4:       c.frame_period = PERIOD_W'($urandom_range(0, ELAPSED_MAX));
      default: c.frame_period = PERIOD_W'($urandom_range(1, 'h30000));
    endcase
    first = $urandom_range(0, 255);
    delta = $urandom_range(1, 6);
    c.range_first = FRAME_W'(first);
    case ($urandom_range(0, 9))
      0:       c.range_last = FRAME_W'(first);
      1:       c.range_last = FRAME_W'($urandom_range(0, 255));
      2, 3, 4: c.range_last = FRAME_W'((first + delta > 255) ? first - delta : first + delta);
      default: c.range_last = FRAME_W'((first < delta) ? first + delta : first - delta);
    endcase
    c.play_flags = FLAGS_W'($urandom_range(0, 7));
    return c;
  endfunction

  // mostly around one frame period so the position moves on most ticks
  function automatic logic [PERIOD_W-1:0] pick_elapsed(int unsigned period);
    int unsigned top;
    top = (2 * period > ELAPSED_MAX) ? ELAPSED_MAX : 2 * period;
    case ($urandom_range(0, 19))
      0, 1, 2: return PERIOD_W'(period);
      3, 4:    return '0;
      5, 6:    return ELAPSED_TOP;
      7, 8:    return PERIOD_W'($urandom_range(0, ELAPSED_MAX));
      default: return PERIOD_W'($urandom_range(0, top));
    endcase
  endfunction

  task automatic random_phase();
    cfg_t c;
    int   n, r;
    c = rand_settings();
    program_regs(c);
    if (settings_run % 10 == 3) hold_req = 1'b1;
    n = $urandom_range(8, 40);
    if ($urandom_range(0, 99) < 85) begin
      // well-formed run: start (or resume), then mostly ticks
      push_item(($urandom_range(0, 4) == 0) ? ACT_RESUME : ACT_START,
                PERIOD_W'($urandom_range(0, 255)));
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 85)      push_item(ACT_TICK, pick_elapsed(32'(c.frame_period)));
        else if (r < 89) push_item(ACT_PAUSE, PERIOD_W'($urandom_range(0, ELAPSED_MAX)));
        else if (r < 93) push_item(ACT_RESUME, PERIOD_W'($urandom_range(0, ELAPSED_MAX)));
        else if (r < 96) push_item(ACT_STOP, PERIOD_W'($urandom_range(0, ELAPSED_MAX)));
        else if (r < 98) push_item(ACT_START, PERIOD_W'($urandom_range(0, ELAPSED_MAX)));
        else             push_item(ACTION_W'($urandom_range(ACT_UNUSED_A, ACT_IGNORE)),
                                   PERIOD_W'($urandom_range(0, ELAPSED_MAX)));
      end
    end else begin
      repeat (n) push_item(ACTION_W'($urandom_range(0, 7)),
                           PERIOD_W'($urandom_range(0, ELAPSED_MAX)));
    end
    settle();
  endtask

  initial begin
    cfg_t c;
    sb = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_TICK;
    m_axis_tready <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_SHEET_COLUMNS;
    cfg_data_i    <= '0;
    offering      = 1'b0;
    burst_left    = 0;
    hold_req      = 1'b0;
    hold_cnt      = 0;
    stall_mode    = 0;
    stall_cycle   = 0;
    quiet_cycles  = 0;
    settings_run  = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: one-frame sheet, zero period, plus the unused codes
    push_item(ACT_TICK, ELAPSED_TOP);
    push_item(ACT_START, '0);
    push_item(ACT_TICK, '0);
    push_item(ACT_TICK, '0);
    push_item(ACT_RESUME, '0);
    push_item(ACT_PAUSE, '0);
    push_item(ACT_UNUSED_A, ELAPSED_TOP);
    push_item(ACT_UNUSED_B, '0);
    push_item(ACT_IGNORE, '0);
    push_item(ACT_STOP, '0);
    settle();

    // saturated sizes, descending range from the top frame, run to finished
    c = '0;
    c.sheet_rows   = 9'd300;
    c.frame_height = 13'd8191;
    c.range_first  = 8'd255;
    c.range_last   = 8'd251;
    c.play_flags   = 3'b100;
    program_regs(c);
    push_item(ACT_START, '0);
    repeat (5) push_item(ACT_TICK, 24'h000100);
    settle();

    // looping ping-pong over three frames, then an empty range
    c = '0;
    c.sheet_columns = 9'd3;
    c.sheet_rows    = 9'd1;
    c.frame_width   = 13'd8191;
    c.frame_height  = 13'd4096;
    c.frame_period  = 24'h010000;
    c.range_first   = 8'd9;
    c.range_last    = 8'd9;
    c.play_flags    = 3'b011;
    program_regs(c);
    push_item(ACT_START, '0);
    push_item(ACT_TICK, 24'h008000);
    push_item(ACT_TICK, 24'h008000);
    push_item(ACT_TICK, ELAPSED_TOP);
    repeat (3) push_item(ACT_TICK, 24'h010000);
    settle();
    c.play_flags = 3'b101;
    program_regs(c);
    push_item(ACT_RESUME, '0);
    push_item(ACT_TICK, 24'h010000);
    settle();

    while (sb.taken < ITEM_TARGET) random_phase();
    settle();

    $display("%0d items over %0d settings, %0d checked: %0d ticks, %0d loop wraps,",
             sb.taken, settings_run, sb.checked, sb.ticks, sb.wraps);
    $display("%0d finished runs, %0d items shown from an empty range",
             sb.finishes, sb.empty_range);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
